@@ rtl/core/rg32_pkg.sv @@
// RadioGatun[32] generator package: command codes, queue entry type, sizes.
// Used by all modules in rtl/core.
`default_nettype none
package rg32_pkg;
    localparam int MILL_N = 19;
    localparam int BELT_N = 39;
    localparam int BLANK_ROUNDS = 17;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_END  = 2'd1,
        CMD_W31  = 2'd2,
        CMD_W16  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] seed_byte;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AUTO,
        ST_ROUNDS,
        ST_DRAW,
        ST_OUT
    } state_t;

    localparam logic [31:0] MOD31 = 32'h7fffffff;
    localparam logic [31:0] MOD31X2 = 32'hfffffffe;
endpackage
`default_nettype wire

@@ rtl/core/rg32_front.sv @@
// Front end: accepts commands into a short FIFO for the sponge engine.
// Depends on rg32_pkg.
`default_nettype none
module rg32_front
    import rg32_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] cmd,
    input  wire logic [7:0] seed_byte,
    output logic            q_valid,
    input  wire logic       q_pop,
    output item_t           q_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    item_t           mem_reg [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [AW:0]     cnt_reg;
    logic            push;

    assign in_stall = (cnt_reg == (AW+1)'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= '{cmd: cmd_t'(cmd), seed_byte: seed_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (q_pop)
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(q_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not advance");
`endif
endmodule
`default_nettype wire

@@ rtl/core/rg32_round.sv @@
// One RadioGatun[32] belt-and-mill round, pure combinational.
// Depends on rg32_pkg.
`default_nettype none
module rg32_round
    import rg32_pkg::*;
(
    input  wire logic [MILL_N-1:0][31:0] mill_in,
    input  wire logic [BELT_N-1:0][31:0] belt_in,
    output logic      [MILL_N-1:0][31:0] mill_out,
    output logic      [BELT_N-1:0][31:0] belt_out
);
    logic [BELT_N-1:0][31:0] bf;
    logic [MILL_N-1:0][31:0] g;
    logic [31:0] x;
    int y, r;

    always_comb
    begin
        bf = belt_in;
        for (int i = 0; i < 12; i++)
            bf[i + (i % 3) * 13] = bf[i + (i % 3) * 13] ^ mill_in[i + 1];
        r = 0;
        for (int i = 0; i < MILL_N; i++)
        begin
            y = (7 * i) % MILL_N;
            x = mill_in[y] ^ (mill_in[(y + 1) % MILL_N] | ~mill_in[(y + 2) % MILL_N]);
            r = (r + i) % 32;
            g[i] = (x >> r) | (x << ((32 - r) % 32));
        end
        for (int i = 0; i < MILL_N; i++)
            mill_out[i] = g[i] ^ g[(i + 1) % MILL_N] ^ g[(i + 4) % MILL_N];
        mill_out[0] = mill_out[0] ^ 32'd1;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 13; j++)
                belt_out[i * 13 + j] = bf[i * 13 + (j + 12) % 13];
        for (int i = 0; i < 3; i++)
            mill_out[i + 13] = mill_out[i + 13] ^ belt_out[i * 13];
    end
endmodule
`default_nettype wire

@@ rtl/core/rg32_engine.sv @@
// Back end: sponge state, seed absorb, round sequencing, draw formatting.
// Depends on rg32_pkg and rg32_round.
`default_nettype none
module rg32_engine
    import rg32_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    input  item_t      q_item,
    output logic       q_pop,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic [30:0] value
);
    logic [MILL_N-1:0][31:0] mill_reg, mill_next, mill_rnd;
    logic [BELT_N-1:0][31:0] belt_reg, belt_next, belt_rnd;
    logic [31:0] aw_reg, aw_next, awv;
    logic [1:0]  bpos_reg, bpos_next, wpos_reg, wpos_next, wk;
    logic        absorbing_reg, absorbing_next, seeded_reg, seeded_next;
    logic        phase_reg, phase_next, half_reg, half_next;
    logic [15:0] saved_reg, saved_next;
    logic [4:0]  rcnt_reg, rcnt_next;
    logic [2:0]  auto_reg, auto_next;
    state_t      st_reg, st_next;
    logic        ov_reg, ov_next;
    logic [30:0] val_reg, val_next;
    logic [31:0] w, sw;
    logic [7:0]  b;

    rg32_round u_round (.mill_in(mill_reg), .belt_in(belt_reg),
                        .mill_out(mill_rnd), .belt_out(belt_rnd));

    assign out_valid = ov_reg;
    assign value     = val_reg;

    always_comb
    begin
        mill_next = mill_reg; belt_next = belt_reg; aw_next = aw_reg;
        bpos_next = bpos_reg; wpos_next = wpos_reg;
        absorbing_next = absorbing_reg; seeded_next = seeded_reg;
        phase_next = phase_reg; half_next = half_reg; saved_next = saved_reg;
        rcnt_next = rcnt_reg; auto_next = auto_reg; st_next = st_reg;
        ov_next = ov_reg; val_next = val_reg; q_pop = 1'b0;
        w = '0; sw = '0; b = '0; awv = '0; wk = '0;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (st_reg)
            ST_IDLE, ST_AUTO:
            begin
                if (st_reg == ST_AUTO || (q_valid && (q_item.cmd == CMD_BYTE
                    || q_item.cmd == CMD_END || absorbing_reg || !seeded_reg)))
                begin
                    // absorb path: a byte, a seed end, or the implicit seed
                    if (!absorbing_reg)
                    begin
                        mill_next = '0; belt_next = '0;
                        aw_next = '0; bpos_next = '0; wpos_next = '0;
                        absorbing_next = 1'b1;
                        // next cycle redoes this item with cleared state
                    end
                    else if (st_reg == ST_AUTO && auto_reg != 3'd4)
                    begin
                        b = 8'h31 + 8'(auto_reg);
                        awv = aw_reg | (32'(b) << {bpos_reg, 3'b000});
                        auto_next = auto_reg + 1'b1;
                        bpos_next = bpos_reg + 1'b1;
                        aw_next = awv;
                        if (bpos_reg == 2'd3)
                        begin
                            wk = wpos_reg;
                            belt_next[wk * 13] = belt_reg[wk * 13] ^ awv;
                            mill_next[16 + wk] = mill_reg[16 + wk] ^ awv;
                            aw_next = '0;
                            wpos_next = wpos_reg + 1'b1;
                        end
                    end
                    else if (st_reg == ST_IDLE && q_item.cmd == CMD_BYTE)
                    begin
                        q_pop = 1'b1;
                        awv = aw_reg | (32'(q_item.seed_byte) << {bpos_reg, 3'b000});
                        bpos_next = bpos_reg + 1'b1;
                        aw_next = awv;
                        if (bpos_reg == 2'd3)
                        begin
                            wk = wpos_reg;
                            belt_next[wk * 13] = belt_reg[wk * 13] ^ awv;
                            mill_next[16 + wk] = mill_reg[16 + wk] ^ awv;
                            aw_next = '0;
                            if (wpos_reg == 2'd2)
                            begin
                                // full block: round on injected state
                                wpos_next = '0;
                                st_next = ST_ROUNDS;
                                rcnt_next = 5'd1;
                            end
                            else
                                wpos_next = wpos_reg + 1'b1;
                        end
                    end
                    else if (st_reg == ST_IDLE && !seeded_reg && !absorbing_reg)
                        st_next = ST_IDLE;
                    else
                    begin
                        // finish seed: pad and inject, then blank rounds
                        awv = aw_reg | (32'd1 << {bpos_reg, 3'b000});
                        wk = wpos_reg;
                        belt_next[wk * 13] = belt_reg[wk * 13] ^ awv;
                        mill_next[16 + wk] = mill_reg[16 + wk] ^ awv;
                        aw_next = '0; bpos_next = '0; wpos_next = '0;
                        absorbing_next = 1'b0; seeded_next = 1'b1;
                        phase_next = 1'b0; half_next = 1'b0; saved_next = '0;
                        rcnt_next = 5'(BLANK_ROUNDS);
                        st_next = ST_ROUNDS;
                        auto_next = '0;
                        if (st_reg == ST_IDLE && q_item.cmd == CMD_END)
                            q_pop = 1'b1;
                    end
                    if (st_reg == ST_IDLE && !seeded_reg && !absorbing_reg
                        && q_item.cmd != CMD_BYTE && q_item.cmd != CMD_END)
                    begin
                        st_next = ST_AUTO;
                        auto_next = '0;
                    end
                    if (st_reg == ST_AUTO && auto_reg == 3'd4 && !absorbing_reg)
                        st_next = ST_AUTO;
                end
                else if (q_valid)
                    st_next = ST_DRAW;
            end
            ST_ROUNDS:
            begin
                mill_next = mill_rnd; belt_next = belt_rnd;
                rcnt_next = rcnt_reg - 1'b1;
                if (rcnt_reg == 5'd1)
                    st_next = ST_IDLE;
            end
            ST_DRAW:
            begin
                if (q_item.cmd == CMD_W16 && half_reg)
                    st_next = ST_OUT;
                else if (!phase_reg)
                begin
                    mill_next = mill_rnd; belt_next = belt_rnd;
                    phase_next = 1'b1;
                    st_next = ST_OUT;
                end
                else
                    st_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    q_pop = 1'b1;
                    ov_next = 1'b1;
                    st_next = ST_IDLE;
                    if (q_item.cmd == CMD_W16 && half_reg)
                    begin
                        half_next = 1'b0;
                        val_next = 31'(saved_reg);
                    end
                    else
                    begin
                        // phase set in DRAW means word 1 of a fresh round
                        w = (phase_reg && rcnt_reg == 5'd0 && auto_reg == 3'd7)
                            ? mill_reg[2] : mill_reg[1];
                        if (!phase_reg || auto_reg == 3'd7)
                            w = mill_reg[2];
                        else
                            w = mill_reg[1];
                        if (auto_reg == 3'd7)
                            phase_next = 1'b0;
                        auto_next = '0;
                        // word mod 2^31-1 needs at most two subtractions
                        if (q_item.cmd == CMD_W31)
                            val_next = (w >= MOD31X2) ? 31'(w - MOD31X2)
                                     : (w >= MOD31) ? 31'(w - MOD31) : w[30:0];
                        else
                        begin
                            sw = {w[23:16], w[31:24], w[7:0], w[15:8]};
                            saved_next = sw[31:16];
                            half_next = 1'b1;
                            val_next = 31'(sw[15:0]);
                        end
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
        // a draw with no round due (phase already set) flags the second-word case
        if (st_reg == ST_DRAW && !(q_item.cmd == CMD_W16 && half_reg) && phase_reg)
            auto_next = 3'd7;
    end

    always_ff @(posedge clk)
    begin
        mill_reg <= mill_next; belt_reg <= belt_next;
        aw_reg <= aw_next; saved_reg <= saved_next; val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpos_reg <= '0; wpos_reg <= '0; absorbing_reg <= 1'b0;
            seeded_reg <= 1'b0; phase_reg <= 1'b0; half_reg <= 1'b0;
            rcnt_reg <= '0; auto_reg <= '0; st_reg <= ST_IDLE; ov_reg <= 1'b0;
        end
        else
        begin
            bpos_reg <= bpos_next; wpos_reg <= wpos_next;
            absorbing_reg <= absorbing_next; seeded_reg <= seeded_next;
            phase_reg <= phase_next; half_reg <= half_next;
            rcnt_reg <= rcnt_next; auto_reg <= auto_next;
            st_reg <= st_next; ov_reg <= ov_next;
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> ov_reg && $stable(val_reg))
        else $error("result dropped under stall");
    a_pop_state: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop without item");
    a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_ROUNDS && rcnt_reg == 5'd1) |=> st_reg == ST_IDLE)
        else $error("round count mismatch");
`endif
endmodule
`default_nettype wire

@@ rtl/core/radiogatun32_random_generator_core.sv @@
// RadioGatun[32] random generator top level.
// Usage:
//   Input channel (in_valid/in_stall): cmd 0 seed byte, 1 end of seed,
//   2 draw 31-bit word, 3 draw 16 bits. Items go into a two-entry queue.
//   Output channel (out_valid/out_stall): one value per draw command.
// Steps:
//   Seed byte: absorbed into the state, plus a round after every twelfth byte.
//   End of seed: pad and inject, then 17 rounds on the single round unit;
//   an empty seed first clears the state.
//   Draw: dispatch, round or wait, then format into the output register.
//   The first seed byte is preceded by a state clear; a draw before any seed
//   first runs the implicit "1234" seed (clear, four bytes, pad, 17 rounds).
// Reset clears control state; the first seed byte clears belt and mill.
// A stalled result holds in the output register; the engine waits to load
// the next result while the queue keeps accepting until full.
`default_nettype none
module radiogatun32_random_generator_core
    import rg32_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  seed_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [30:0]      value
);
    logic  q_valid, q_pop;
    item_t q_item;

    rg32_front #(.DEPTH(DEPTH)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .cmd, .seed_byte,
        .q_valid, .q_pop, .q_item);

    rg32_engine u_engine (
        .clk, .rst_n, .q_valid, .q_item, .q_pop,
        .out_valid, .out_stall, .value);
endmodule
`default_nettype wire

@@ verif/rg32_checker.sv @@
// Checker for the RadioGatun[32] generator core: watches both channels,
// predicts draw results with its own belt-and-mill model, compares them.
// Depends on rg32_pkg for the command codes.
module rg32_checker
    import rg32_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  seed_byte,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [30:0] value,
    output int               errors,
    output int               pending,
    output int               draws_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] belt [BELT_N];
    logic [31:0] mill [MILL_N];
    logic [31:0] part_word;
    int unsigned byte_idx;
    int unsigned word_idx;
    bit          in_seed;
    bit          have_seed;
    bit          odd_draw;
    bit          half_held;
    logic [15:0] held_half;
    logic [30:0] expected_values [$];

    function automatic logic [31:0] ror(logic [31:0] x, int unsigned r);
        return (r == 0) ? x : ((x >> r) | (x << (32 - r)));
    endfunction

    task automatic mix_round();
        logic [31:0] g [MILL_N];
        logic [31:0] nb [BELT_N];
        int unsigned y;
        int unsigned r;
        r = 0;
        for (int i = 0; i < 12; i++)
            belt[i + (i % 3) * 13] ^= mill[i + 1];
        for (int i = 0; i < MILL_N; i++)
        begin
            y = (7 * i) % MILL_N;
            r = (r + i) & 31;
            g[i] = ror(mill[y] ^ (mill[(y + 1) % MILL_N] | ~mill[(y + 2) % MILL_N]), r);
        end
        for (int i = 0; i < MILL_N; i++)
            mill[i] = g[i] ^ g[(i + 1) % MILL_N] ^ g[(i + 4) % MILL_N];
        mill[0] ^= 32'd1;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 13; j++)
                nb[i * 13 + j] = belt[i * 13 + (j + 12) % 13];
        belt = nb;
        for (int i = 0; i < 3; i++)
            mill[i + 13] ^= belt[i * 13];
    endtask

    task automatic clear_state();
        foreach (belt[i]) belt[i] = '0;
        foreach (mill[i]) mill[i] = '0;
        part_word = '0;
        byte_idx = 0;
        word_idx = 0;
        in_seed = 1;
    endtask

    task automatic fold_word();
        belt[(word_idx % 3) * 13] ^= part_word;
        mill[16 + word_idx % 3] ^= part_word;
    endtask

    task automatic absorb_byte(logic [7:0] b);
        if (!in_seed)
            clear_state();
        part_word |= 32'(b) << (8 * byte_idx);
        byte_idx++;
        if (byte_idx == 4)
        begin
            fold_word();
            part_word = '0;
            byte_idx = 0;
            word_idx++;
            if (word_idx == 3)
            begin
                mix_round();
                word_idx = 0;
            end
        end
    endtask

    task automatic finish_seed();
        if (!in_seed)
            clear_state();
        part_word |= 32'd1 << (8 * byte_idx);
        fold_word();
        for (int i = 0; i < BLANK_ROUNDS; i++)
            mix_round();
        part_word = '0;
        byte_idx = 0;
        word_idx = 0;
        in_seed = 0;
        have_seed = 1;
        odd_draw = 0;
        half_held = 0;
        held_half = '0;
    endtask

    task automatic next_word(output logic [31:0] w);
        if (!odd_draw)
        begin
            mix_round();
            odd_draw = 1;
            w = mill[1];
        end
        else
        begin
            odd_draw = 0;
            w = mill[2];
        end
    endtask

    task automatic predict_beat(cmd_t c, logic [7:0] b);
        logic [31:0] w;
        logic [31:0] s;
        case (c)
            CMD_BYTE: absorb_byte(b);
            CMD_END:  finish_seed();
            default:
            begin
                if (in_seed)
                    finish_seed();
                else if (!have_seed)
                begin
                    absorb_byte(8'h31);
                    absorb_byte(8'h32);
                    absorb_byte(8'h33);
                    absorb_byte(8'h34);
                    finish_seed();
                end
                if (c == CMD_W31)
                begin
                    next_word(w);
                    expected_values.push_back(31'(w % MOD31));
                end
                else if (!half_held)
                begin
                    next_word(w);
                    s = {w[23:16], w[31:24], w[7:0], w[15:8]};
                    held_half = s[31:16];
                    half_held = 1;
                    expected_values.push_back(31'(s[15:0]));
                end
                else
                begin
                    half_held = 0;
                    expected_values.push_back(31'(held_half));
                end
            end
        endcase
    endtask

    initial
    begin
        foreach (belt[i]) belt[i] = '0;
        foreach (mill[i]) mill[i] = '0;
        part_word = '0;
        byte_idx = 0;
        word_idx = 0;
        in_seed = 0;
        have_seed = 0;
        odd_draw = 0;
        half_held = 0;
        held_half = '0;
        errors = 0;
        draws_seen = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_beat(cmd_t'(cmd), seed_byte);
            if (out_valid && !out_stall)
            begin
                draws_seen++;
                if (expected_values.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat: value %0d", value);
                end
                else if (expected_values[0] !== value)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("value mismatch: expected %0d got %0d",
                                 expected_values[0], value);
                    void'(expected_values.pop_front());
                end
                else
                    void'(expected_values.pop_front());
            end
            pending = expected_values.size();
        end
    end
endmodule

@@ verif/tb.sv @@
// Testbench top for radiogatun32_random_generator_core: drives seed and
// draw commands with random gaps and stalls; checking lives in rg32_checker.
// Depends on rg32_pkg and the core RTL.
module tb;
    import rg32_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_BYTE;
    logic [7:0]  seed_byte = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [30:0] value;
    int          errors;
    int          pending;
    int          draws_seen;
    int          beats_sent = 0;
    int          stall_left = 0;
    bit          calm = 0;

    always #5 clk = ~clk;

    radiogatun32_random_generator_core dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .seed_byte(seed_byte), .out_valid(out_valid),
        .out_stall(out_stall), .value(value)
    );

    rg32_checker chk (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .seed_byte(seed_byte), .out_valid(out_valid),
        .out_stall(out_stall), .value(value), .errors(errors),
        .pending(pending), .draws_seen(draws_seen)
    );

    // receiver stalls in bursts of random length
    always @(posedge clk)
    begin
        if (calm)
        begin
            out_stall <= 0;
            stall_left <= 0;
        end
        else if (stall_left > 1)
        begin
            out_stall <= 1;
            stall_left <= stall_left - 1;
        end
        else if (stall_left == 1)
        begin
            out_stall <= 0;
            stall_left <= 0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_stall <= 1;
            stall_left <= $urandom_range(1, 9);
        end
    end

    // one beat, with an optional idle burst first; valid stays up between
    // back-to-back beats
    task automatic send(cmd_t c, logic [7:0] b);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        cmd <= c;
        seed_byte <= b;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        int n;
        int roll;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // draws before any seed, both kinds
        send(CMD_W16, 8'h00);
        send(CMD_W16, 8'h00);
        send(CMD_W31, 8'h00);
        send(CMD_W31, 8'h00);
        send(CMD_END, 8'h00);     // empty seed
        send(CMD_W31, 8'h00);
        send(CMD_BYTE, 8'h00);    // zero byte inside a seed
        send(CMD_BYTE, 8'hff);
        send(CMD_BYTE, 8'h55);
        send(CMD_BYTE, 8'haa);
        send(CMD_BYTE, 8'h01);
        send(CMD_END, 8'h00);
        send(CMD_W16, 8'h00);
        send(CMD_W31, 8'h00);
        send(CMD_W16, 8'h00);
        send(CMD_BYTE, 8'h80);
        send(CMD_W16, 8'h00);     // draw ends the open seed
        send(CMD_W16, 8'h00);
        drain();                  // sender holds off until all results are in
        for (int i = 0; i < 330; i++)
        begin
            if (i == 275)
                calm = 1;
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                // a seed: usually short, sometimes a full block or longer
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 30)
                                                : $urandom_range(0, 6);
                for (int k = 0; k < n; k++)
                    send(CMD_BYTE, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 2) != 0)
                    send(CMD_END, 8'($urandom_range(0, 255)));
            end
            else if (roll < 10)
                send(CMD_END, 8'($urandom_range(0, 255)));
            else
                send($urandom_range(0, 1) ? CMD_W31 : CMD_W16,
                     8'($urandom_range(0, 255)));
        end
        drain();
        $display("%0d beats sent, %0d results checked: seeds, pad cases, both draw widths",
                 beats_sent, draws_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
